// ===== rtl/vn2d_pkg.sv =====
// Shared types, hash constants and the cosine weight table for the value noise core.
`timescale 1ns / 1ps

package vn2d_pkg;

   // Lattice hash constants, all used with 32-bit wrap.
   localparam logic [31:0] HASH_ROW_MUL = 32'd57;
   localparam logic [31:0] HASH_X_OFS   = 32'd3;
   localparam logic [31:0] HASH_Y_OFS   = 32'd5;
   localparam int          HASH_SHIFT   = 13;
   localparam logic [31:0] HASH_MUL_A   = 32'd15731;
   localparam logic [31:0] HASH_ADD_A   = 32'd789221;
   localparam logic [31:0] HASH_ADD_B   = 32'd1376312589;
   localparam logic [31:0] HASH_MASK    = 32'h7fff_ffff;
   localparam logic [31:0] NOISE_ONE    = 32'h4000_0000;

   // Sizes of the weight table and of the arithmetic words.
   localparam int ROM_DEPTH   = 256;
   localparam int ROM_AW      = 8;
   localparam int WEIGHT_BITS = 17;
   localparam int NOISE_BITS  = 32;
   localparam int SMOOTH_BITS = 36;
   localparam int DIFF_BITS   = 37;
   localparam int PROD_BITS   = 55;
   localparam int OUT_BITS    = 18;

   typedef logic [WEIGHT_BITS-1:0]        weight_type;
   typedef weight_type                    weight_rom_type [ROM_DEPTH];
   typedef logic signed [NOISE_BITS-1:0]  noise_type;
   typedef logic signed [SMOOTH_BITS-1:0] smooth_type;
   typedef logic signed [DIFF_BITS-1:0]   diff_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;

   // Restoring long division; it only runs while the weight table is built.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // One weight entry: Q30 sine series of pi*k/512, squared to Q0.16.
   function automatic weight_type cos_weight(input logic [ROM_AW-1:0] k);
      logic [63:0]        t;
      logic [63:0]        t2;
      logic [63:0]        term;
      logic [63:0]        s;
      logic [63:0]        dv;
      logic signed [63:0] acc;
      t    = (64'd3373259426 * {56'd0, k}) >> 9;
      t2   = (t * t) >> 30;
      term = t;
      acc  = $signed(t);
      for (int n = 1; n <= 8; n++) begin
         dv   = 64'((2 * n) * (2 * n + 1));
         term = udiv64((term * t2) >> 30, dv);
         if ((n & 1) == 1) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      if (acc < 0) begin
         acc = 64'sd0;
      end
      s = $unsigned(acc);
      if (s > 64'd1073741824) begin
         s = 64'd1073741824;
      end
      return WEIGHT_BITS'((s * s + (64'd1 << 43)) >> 44);
   endfunction

   function automatic weight_rom_type build_weight_rom();
      weight_rom_type rom;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         rom[k] = cos_weight(ROM_AW'(k));
      end
      return rom;
   endfunction

   // Cosine blend weights, worked out at elaboration.
   localparam weight_rom_type WEIGHT_ROM = build_weight_rom();

endpackage

// ===== rtl/value_noise_2d_cosine_interp_core.sv =====
// Pipelined 2D lattice value noise with 3x3 smoothing and cosine blending.
`timescale 1ns / 1ps

// Channel   Ports                                          Handshake
// request   req_x_coord, req_y_coord, req_octave           start high, busy low
// response  rsp_noise_value                                rsp_valid, one cycle
//
// An item is taken in every cycle in which start is high; busy is always low.
// Each result passes through eleven register stages: hash seed, two hash
// multiplies, final hash multiply, smoothing, and three stages each for the x
// blend and the y blend.
// Reset clears only the valid bits of the stages. The receiver cannot stall.
module value_noise_2d_cosine_interp_core #(
   parameter int FRACTION_BITS = 8,
   parameter int INTEGER_BITS  = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [INTEGER_BITS+FRACTION_BITS-1:0]   req_x_coord,
   input  logic [INTEGER_BITS+FRACTION_BITS-1:0]   req_y_coord,
   input  logic [3:0]                              req_octave,
   output logic                                    rsp_valid,
   output logic signed [vn2d_pkg::OUT_BITS-1:0]    rsp_noise_value
);

   localparam int CoordBits = INTEGER_BITS + FRACTION_BITS;
   localparam int Stages    = 11;

   // Valid bits travelling with the items.
   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] vld_in;

   assign busy = 1'b0;

   always_comb begin
      vld_in = {vld_ff[Stages-2:0], start & ~busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: lattice seeds for the 4x4 grid and the weight lookups.
   logic [INTEGER_BITS-1:0]     lat_x;
   logic [INTEGER_BITS-1:0]     lat_y;
   logic [FRACTION_BITS+7:0]    frac_x;
   logic [FRACTION_BITS+7:0]    frac_y;
   logic [31:0]                 seed_in [16];
   logic [31:0]                 seed_ff [16];
   vn2d_pkg::weight_type        wx_in;
   vn2d_pkg::weight_type        wy_in;
   vn2d_pkg::weight_type        wx_ff [6];
   vn2d_pkg::weight_type        wy_ff [9];

   assign lat_x  = req_x_coord[CoordBits-1:FRACTION_BITS];
   assign lat_y  = req_y_coord[CoordBits-1:FRACTION_BITS];
   assign frac_x = {req_x_coord[FRACTION_BITS-1:0], 8'd0};
   assign frac_y = {req_y_coord[FRACTION_BITS-1:0], 8'd0};
   assign wx_in  = vn2d_pkg::WEIGHT_ROM[frac_x[FRACTION_BITS+7:FRACTION_BITS]];
   assign wy_in  = vn2d_pkg::WEIGHT_ROM[frac_y[FRACTION_BITS+7:FRACTION_BITS]];

   // Lane dy*4+dx covers lattice point (X-1+dx, Y-1+dy).
   for (genvar ln = 0; ln < 16; ln++) begin : g_seed
      logic [31:0] hx;
      logic [31:0] hy;
      logic [31:0] nb;
      assign hx = 32'(lat_x) + 32'(ln % 4) - 32'd1 + 32'(req_octave)
                  + vn2d_pkg::HASH_X_OFS;
      assign hy = 32'(lat_y) + 32'(ln / 4) - 32'd1 + 32'(req_octave)
                  + vn2d_pkg::HASH_Y_OFS;
      assign nb = hx + hy * vn2d_pkg::HASH_ROW_MUL;
      assign seed_in[ln] = nb ^ (nb << vn2d_pkg::HASH_SHIFT);
   end

   // Stages 2 to 4: the hash polynomial, one multiply per stage.
   logic [31:0]         sq_in   [16];
   logic [31:0]         sq_ff   [16];
   logic [31:0]         seed2_ff[16];
   logic [31:0]         poly_in [16];
   logic [31:0]         poly_ff [16];
   logic [31:0]         seed3_ff[16];
   vn2d_pkg::noise_type noise_in[16];
   vn2d_pkg::noise_type noise_ff[16];

   for (genvar ln = 0; ln < 16; ln++) begin : g_hash
      logic [31:0] hv;
      assign sq_in[ln]   = seed_ff[ln] * seed_ff[ln];
      assign poly_in[ln] = sq_ff[ln] * vn2d_pkg::HASH_MUL_A + vn2d_pkg::HASH_ADD_A;
      assign hv          = (seed3_ff[ln] * poly_ff[ln] + vn2d_pkg::HASH_ADD_B)
                           & vn2d_pkg::HASH_MASK;
      assign noise_in[ln] = $signed(vn2d_pkg::NOISE_ONE - hv);
   end

   always_ff @(posedge clock) begin
      for (int ln = 0; ln < 16; ln++) begin
         seed_ff[ln]  <= seed_in[ln];
         sq_ff[ln]    <= sq_in[ln];
         seed2_ff[ln] <= seed_ff[ln];
         poly_ff[ln]  <= poly_in[ln];
         seed3_ff[ln] <= seed2_ff[ln];
         noise_ff[ln] <= noise_in[ln];
      end
   end

   // Weight delay lines, tapped where each blend needs them.
   always_ff @(posedge clock) begin
      wx_ff[0] <= wx_in;
      wy_ff[0] <= wy_in;
      for (int st = 1; st < 6; st++) begin
         wx_ff[st] <= wx_ff[st-1];
      end
      for (int st = 1; st < 9; st++) begin
         wy_ff[st] <= wy_ff[st-1];
      end
   end

   // Stage 5: smoothing of the four cells around the point.
   vn2d_pkg::smooth_type sm_in [4];
   vn2d_pkg::smooth_type sm_ff [4];

   for (genvar cr = 0; cr < 4; cr++) begin : g_smooth
      localparam int Cx = cr % 2;
      localparam int Cy = cr / 2;
      vn2d_pkg::smooth_type corners;
      vn2d_pkg::smooth_type sides;
      vn2d_pkg::smooth_type center;
      assign corners = 36'(noise_ff[Cy*4+Cx])       + 36'(noise_ff[Cy*4+Cx+2])
                     + 36'(noise_ff[(Cy+2)*4+Cx])   + 36'(noise_ff[(Cy+2)*4+Cx+2]);
      assign sides   = 36'(noise_ff[(Cy+1)*4+Cx])   + 36'(noise_ff[(Cy+1)*4+Cx+2])
                     + 36'(noise_ff[Cy*4+Cx+1])     + 36'(noise_ff[(Cy+2)*4+Cx+1]);
      assign center  = 36'(noise_ff[(Cy+1)*4+Cx+1]);
      assign sm_in[cr] = corners + (sides <<< 1) + (center <<< 2);
   end

   always_ff @(posedge clock) begin
      for (int cr = 0; cr < 4; cr++) begin
         sm_ff[cr] <= sm_in[cr];
      end
   end

   // Stages 6 to 8: blend along x as a + (b - a) * w / 2^16.
   vn2d_pkg::diff_type   dx_ff [2];
   vn2d_pkg::smooth_type ax_ff [2];
   vn2d_pkg::smooth_type ax2_ff[2];
   vn2d_pkg::prod_type   px_ff [2];
   vn2d_pkg::smooth_type ix_ff [2];
   vn2d_pkg::prod_type   px_in [2];
   vn2d_pkg::smooth_type ix_in [2];

   always_comb begin
      for (int rw = 0; rw < 2; rw++) begin
         px_in[rw] = 55'(dx_ff[rw]) * $signed({38'd0, wx_ff[5]});
         ix_in[rw] = 36'(37'(ax2_ff[rw]) + 37'(px_ff[rw] >>> 16));
      end
   end

   always_ff @(posedge clock) begin
      for (int rw = 0; rw < 2; rw++) begin
         dx_ff[rw]  <= 37'(sm_ff[2*rw+1]) - 37'(sm_ff[2*rw]);
         ax_ff[rw]  <= sm_ff[2*rw];
         px_ff[rw]  <= px_in[rw];
         ax2_ff[rw] <= ax_ff[rw];
         ix_ff[rw]  <= ix_in[rw];
      end
   end

   // Stages 9 to 11: blend along y, then reduce to Q.16.
   vn2d_pkg::diff_type                  dy_ff;
   vn2d_pkg::smooth_type                ay_ff;
   vn2d_pkg::smooth_type                ay2_ff;
   vn2d_pkg::prod_type                  py_ff;
   vn2d_pkg::prod_type                  py_in;
   logic signed [vn2d_pkg::DIFF_BITS-1:0] fin_sum;
   logic signed [vn2d_pkg::OUT_BITS-1:0]  rsp_noise_value_ff;
   logic signed [vn2d_pkg::OUT_BITS-1:0]  rsp_noise_value_in;

   assign py_in              = 55'(dy_ff) * $signed({38'd0, wy_ff[8]});
   assign fin_sum            = 37'(ay2_ff) + 37'(py_ff >>> 16);
   assign rsp_noise_value_in = 18'(fin_sum >>> 18);

   always_ff @(posedge clock) begin
      dy_ff              <= 37'(ix_ff[1]) - 37'(ix_ff[0]);
      ay_ff              <= ix_ff[0];
      py_ff              <= py_in;
      ay2_ff             <= ay_ff;
      rsp_noise_value_ff <= rsp_noise_value_in;
   end

   assign rsp_valid       = vld_ff[Stages-1];
   assign rsp_noise_value = rsp_noise_value_ff;

   // Every result comes from an item accepted into the pipeline.
   a_result_has_item : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Stages))
      else $error("result without a matching item");

   // Results stay within the unit range in Q.16.
   a_result_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_noise_value >= -18'sd65536 && rsp_noise_value <= 18'sd65536))
      else $error("noise result out of range");

   // Lattice noise stays within one in Q.30.
   a_noise_range : assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (noise_ff[0] <= 32'sh4000_0000 && noise_ff[0] > -32'sh4000_0000))
      else $error("lattice noise out of range");

   // Blend weights never exceed one in Q0.16.
   a_weight_range : assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] |-> (wx_ff[5] <= 17'd65536 && wy_ff[5] <= 17'd65536))
      else $error("blend weight out of range");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the 2D cosine-blended value noise core.
`timescale 1ns / 1ps

// Scoreboard that predicts the noise for each accepted item and checks results in order.
class noise_scoreboard;
   logic signed [17:0] pending_noise[$];
   int                 error_count;
   logic [16:0]        weight_table[256];

   function new();
      error_count = 0;
      for (int k = 0; k < 256; k++) begin
         weight_table[k] = series_weight(k[7:0]);
      end
   endfunction

   // Squared sine series in Q30, reduced to a Q0.16 blend weight.
   function automatic logic [16:0] series_weight(logic [7:0] k);
      logic [63:0]        angle;
      logic [63:0]        angle_sq;
      logic [63:0]        term;
      logic [63:0]        mag;
      longint             sum;
      angle    = (64'd3373259426 * k) / 64'd512;
      angle_sq = (angle * angle) >> 30;
      term     = angle;
      sum      = longint'(angle);
      for (int n = 1; n <= 8; n++) begin
         term = ((term * angle_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      mag = 64'(sum);
      if (mag > 64'd1073741824) begin
         mag = 64'd1073741824;
      end
      return 17'((mag * mag + (64'd1 << 43)) >> 44);
   endfunction

   // Lattice value in Q.30 from the wrapped 32-bit hash.
   function automatic longint lattice_value(logic [31:0] lx, logic [31:0] ly, logic [31:0] oct);
      logic [31:0] n;
      logic [31:0] h;
      n = (lx + oct + 32'd3) + (ly + oct + 32'd5) * 32'd57;
      n = n ^ (n << 13);
      h = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
      return longint'(1073741824) - longint'({32'd0, h});
   endfunction

   function automatic longint smoothed_value(logic [31:0] lx, logic [31:0] ly, logic [31:0] oct);
      longint corners;
      longint sides;
      corners = lattice_value(lx - 1, ly - 1, oct) + lattice_value(lx + 1, ly - 1, oct)
              + lattice_value(lx - 1, ly + 1, oct) + lattice_value(lx + 1, ly + 1, oct);
      sides = lattice_value(lx - 1, ly, oct) + lattice_value(lx + 1, ly, oct)
            + lattice_value(lx, ly - 1, oct) + lattice_value(lx, ly + 1, oct);
      return corners + 2 * sides + 4 * lattice_value(lx, ly, oct);
   endfunction

   // Notes an accepted item and queues the noise it must give.
   function void note_item(logic [23:0] xc, logic [23:0] yc, logic [3:0] oct);
      logic [31:0] lx;
      logic [31:0] ly;
      longint      wx;
      longint      wy;
      longint      v1, v2, v3, v4, i1, i2, r;
      lx = {16'd0, xc[23:8]};
      ly = {16'd0, yc[23:8]};
      wx = weight_table[xc[7:0]];
      wy = weight_table[yc[7:0]];
      v1 = smoothed_value(lx, ly, oct);
      v2 = smoothed_value(lx + 1, ly, oct);
      v3 = smoothed_value(lx, ly + 1, oct);
      v4 = smoothed_value(lx + 1, ly + 1, oct);
      // Arithmetic shifts give truncation toward minus infinity.
      i1 = (v1 * (65536 - wx) + v2 * wx) >>> 16;
      i2 = (v3 * (65536 - wx) + v4 * wx) >>> 16;
      r  = (i1 * (65536 - wy) + i2 * wy) >>> 34;
      pending_noise.push_back(r[17:0]);
   endfunction

   // Checks one result against the oldest expectation.
   function void check_result(logic signed [17:0] actual);
      logic signed [17:0] expected;
      if (pending_noise.size() == 0) begin
         $error("noise_value: unexpected result %0d", actual);
         error_count++;
      end else begin
         expected = pending_noise.pop_front();
         if (actual !== expected) begin
            $error("noise_value: expected %0d, actual %0d", expected, actual);
            error_count++;
         end
      end
   endfunction
endclass

module testbench;
   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [23:0]        req_x_coord;
   logic [23:0]        req_y_coord;
   logic [3:0]         req_octave;
   logic               rsp_valid;
   logic signed [17:0] rsp_noise_value;

   noise_scoreboard    noise_board;
   int                 idle_cycles;
   bit                 no_gaps;

   value_noise_2d_cosine_interp_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_octave      (req_octave),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value)
   );

   // Clock with a 2 ns period.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Results are checked and items noted at the edge that accepts them.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         noise_board.note_item(req_x_coord, req_y_coord, req_octave);
      end
      if (!reset && rsp_valid) begin
         noise_board.check_result(rsp_noise_value);
      end
   end

   // Watchdog on cycles in which no item is accepted and no result arrives.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 2000) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   // Drives one item, holding start until it is accepted, after a random gap unless no_gaps is set.
   task automatic send_item(logic [23:0] xc, logic [23:0] yc, logic [3:0] oct);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_x_coord <= xc;
      req_y_coord <= yc;
      req_octave  <= oct;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (noise_board.pending_noise.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [23:0] xc;
      logic [23:0] yc;
      noise_board = new();
      no_gaps     = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_x_coord = '0;
      req_y_coord = '0;
      req_octave  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: lattice origin (neighbour below zero), all-ones, fraction ends.
      send_item(24'h000000, 24'h000000, 4'd0);
      send_item(24'hffffff, 24'hffffff, 4'd15);
      send_item(24'h0000ff, 24'h000000, 4'd3);
      send_item(24'h000000, 24'h0000ff, 4'd7);
      send_item(24'hffff00, 24'h000080, 4'd1);
      send_item(24'h000080, 24'hffff00, 4'd8);
      send_item(24'h555555, 24'haaaaaa, 4'd5);
      send_item(24'haaaaaa, 24'h555555, 4'd10);
      send_item(24'h000140, 24'h0001c0, 4'd0);
      send_item(24'h7fffff, 24'h800000, 4'd12);

      // Hold off until every expected result is in.
      drain_results();

      // Random items, with one back-to-back stretch.
      for (int n = 0; n < 700; n++) begin
         no_gaps = (n >= 300 && n < 400);
         case ($urandom_range(0, 3))
            0: begin
               xc = 24'($urandom_range(0, 1023));
               yc = 24'($urandom_range(0, 1023));
            end
            1: begin
               xc = 24'hffffff - 24'($urandom_range(0, 1023));
               yc = 24'hffffff - 24'($urandom_range(0, 1023));
            end
            default: begin
               xc = 24'($urandom());
               yc = 24'($urandom());
            end
         endcase
         send_item(xc, yc, 4'($urandom_range(0, 15)));
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (noise_board.error_count == 0 && noise_board.pending_noise.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule
